>>> design/ddsseq_pkg.sv
// ============================================================================
// ddsseq_pkg - shared types and constants for the dds command sequencer
// Channel count, field widths, word codes and reciprocal constants for the
// shared multiply unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ddsseq_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// stored setting widths
	localparam int FREQ_W = 25;
	localparam int PH_W   = 9;
	localparam int AMP_W  = 12;

	localparam logic [31:0]       FREQ_LIMIT = 32'd30000000;
	localparam logic [15:0]       PH_LIMIT   = 16'd360;
	localparam logic [15:0]       AMP_LIMIT  = 16'd2100;
	localparam logic [FREQ_W-1:0] FREQ_MAX   = FREQ_W'(FREQ_LIMIT);
	localparam logic [PH_W-1:0]   PH_MAX     = PH_W'(PH_LIMIT);
	localparam logic [AMP_W-1:0]  AMP_MAX    = AMP_W'(AMP_LIMIT);

	// serial word constants
	localparam logic [15:0] DDS_CTRL  = 16'h2100;
	localparam logic [15:0] FREQ_TAG  = 16'h4000;
	localparam logic [15:0] PHASE_TAG = 16'hC000;
	localparam logic [15:0] ACC_RESET = 16'h2000;
	localparam logic [7:0]  DAC_ADDR0 = 8'hC0;
	localparam logic [7:0]  DAC_ADDR1 = 8'hC2;
	localparam logic [7:0]  NO_ADDR   = 8'h00;

	// output word kinds
	localparam logic [1:0] KIND_DDS = 2'd0;
	localparam logic [1:0] KIND_SPI = 2'd1;
	localparam logic [1:0] KIND_I2C = 2'd2;
	localparam logic [1:0] KIND_ACC = 2'd3;

	// multiply unit widths
	localparam int MX_W   = 23;
	localparam int MC_W   = 24;
	localparam int PROD_W = MX_W + MC_W;
	localparam int QUO_W  = 13;
	localparam int BASE_W = 11;
	localparam logic [BASE_W-1:0] DAC_MID = 11'd1200;

	// divide by constant as (x * ceil(2^s / d)) >> s, exact over the operand range
	localparam int DIV7_S    = 16;
	localparam int DIV360_S  = 30;
	localparam int DIVSPI_S  = 34;
	localparam int DIVI2C_S  = 34;
	localparam logic [63:0] DIV7_M64   = ((64'd1 << DIV7_S) + 64'd7 - 64'd1) / 64'd7;
	localparam logic [63:0] DIV360_M64 = ((64'd1 << DIV360_S) + 64'd360 - 64'd1) / 64'd360;
	localparam logic [63:0] DIVSPI_M64 = ((64'd1 << DIVSPI_S) + 64'd2500 - 64'd1) / 64'd2500;
	localparam logic [63:0] DIVI2C_M64 = ((64'd1 << DIVI2C_S) + 64'd3300 - 64'd1) / 64'd3300;

	typedef enum logic [1:0] {
		OP_DIV7,
		OP_DIV360,
		OP_DIV_SPI,
		OP_DIV_I2C
	} mul_op_t;

	function automatic logic [MC_W-1:0] mul_const(input mul_op_t op);
		logic [MC_W-1:0] m;
		unique case (op)
			OP_DIV7:    m = MC_W'(DIV7_M64);
			OP_DIV360:  m = MC_W'(DIV360_M64);
			OP_DIV_SPI: m = MC_W'(DIVSPI_M64);
			OP_DIV_I2C: m = MC_W'(DIVI2C_M64);
			default:    m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

>>> design/four_channel_dds_command_sequencer.sv
// ============================================================================
// four_channel_dds_command_sequencer - dds/dac serial word sequencer
// Stores per-channel settings from set commands and emits the full serial
// word run for every channel after each command.
// ============================================================================
// Each accepted command optionally updates one channel (tuser 1..4) and then
// produces a run of 6*CHANNELS+1 output transfers: per channel the dds control,
// low and high frequency, phase, spi dac and i2c dac words, then one broadcast
// accumulator reset with tlast high. The input is ready only between runs.
// With the output never stalled the output register sets the pace of a run
// at one word per cycle, and the shared multiply unit finishes each
// channel's four divides inside its six-word slot. Output backpressure
// stretches the run.
`timescale 1ns / 1ps
`default_nettype none

module four_channel_dds_command_sequencer
	import ddsseq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // frequency_hz, phase_deg, amplitude_mv
	input  wire logic [7:0]  s_tuser,   // channel_sel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // data_word, bus_address
	output logic      [4:0]  m_tuser,   // target_kind, target_channel
	output logic             m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAN,
		ST_RESET
	} state_t;

	state_t              state_q;
	logic [CH_IDX_W-1:0] chan_q;
	logic [2:0]          cstep_q;
	logic [2:0]          wstep_q;
	logic [BASE_W-1:0]   base_q;
	logic [QUO_W-1:0]    phase_q;
	logic [QUO_W-1:0]    spi_q;
	logic [QUO_W-1:0]    i2c_q;

	logic                out_valid_q;
	logic [1:0]          out_kind_q;
	logic [2:0]          out_chan_q;
	logic [15:0]         out_word_q;
	logic [7:0]          out_addr_q;
	logic                out_last_q;

	logic                accept;
	logic                slot_free;
	logic                word_ok;
	logic                emit;
	logic [FREQ_W-1:0]   rd_freq;
	logic [PH_W-1:0]     rd_phase;
	logic [AMP_W-1:0]    rd_amp;
	logic [FREQ_W+1:0]   fw;
	mul_op_t             mul_op;
	logic [MX_W-1:0]     mul_x;
	logic [QUO_W-1:0]    mul_q;
	logic [1:0]          word_kind;
	logic [15:0]         word_data;
	logic [7:0]          word_addr;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	// first three words need no divide; the rest wait for their quotient
	assign word_ok   = (wstep_q < 3'd3) || (cstep_q >= wstep_q);
	assign emit      = (state_q == ST_CHAN) && slot_free && word_ok;
	assign fw        = {rd_freq, 2'b00};

	ddsseq_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_sel   (s_tuser),
		.wr_freq  (s_tdata[31:0]),
		.wr_phase (s_tdata[47:32]),
		.wr_amp   (s_tdata[63:48]),
		.rd_idx   (chan_q),
		.rd_freq  (rd_freq),
		.rd_phase (rd_phase),
		.rd_amp   (rd_amp)
	);

	// operand schedule for one channel
	always_comb begin
		case (cstep_q)
			3'd0: begin
				mul_op = OP_DIV7;
				mul_x  = MX_W'({rd_amp, 2'b00});
			end
			3'd1: begin
				mul_op = OP_DIV360;
				mul_x  = MX_W'({rd_phase, 12'h000});
			end
			3'd2: begin
				mul_op = OP_DIV_SPI;
				mul_x  = MX_W'({base_q, 12'h000});
			end
			default: begin
				mul_op = OP_DIV_I2C;
				mul_x  = MX_W'({base_q, 12'h000});
			end
		endcase
	end

	ddsseq_mul u_mul (
		.clk (clk),
		.op  (mul_op),
		.x   (mul_x),
		.q   (mul_q)
	);

	always_comb begin
		word_kind = KIND_DDS;
		word_addr = NO_ADDR;
		case (wstep_q)
			3'd0: word_data = DDS_CTRL;
			3'd1: word_data = {2'b01, fw[13:0]};
			3'd2: word_data = 16'(fw[FREQ_W+1:14]) + FREQ_TAG;
			3'd3: word_data = 16'(phase_q) + PHASE_TAG;
			3'd4: begin
				word_kind = KIND_SPI;
				word_data = 16'({spi_q, 2'b00});
			end
			default: begin
				word_kind = KIND_I2C;
				word_data = 16'(i2c_q);
				word_addr = (chan_q == '0) ? DAC_ADDR0 : DAC_ADDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_q      <= '0;
			cstep_q     <= '0;
			wstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit || (state_q == ST_RESET && slot_free)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHAN;
						chan_q  <= '0;
						cstep_q <= '0;
						wstep_q <= '0;
					end
				end
				ST_CHAN: begin
					if (cstep_q != 3'd5) begin
						cstep_q <= cstep_q + 3'd1;
					end
					if (emit) begin
						if (wstep_q == 3'd5) begin
							cstep_q <= '0;
							wstep_q <= '0;
							if (chan_q == CH_IDX_W'(CHANNELS - 1)) begin
								state_q <= ST_RESET;
							end else begin
								chan_q <= chan_q + CH_IDX_W'(1);
							end
						end else begin
							wstep_q <= wstep_q + 3'd1;
						end
					end
				end
				ST_RESET: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// quotient capture and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_CHAN) begin
			case (cstep_q)
				3'd1:    base_q  <= DAC_MID - BASE_W'(mul_q);
				3'd2:    phase_q <= mul_q;
				3'd3:    spi_q   <= mul_q;
				3'd4:    i2c_q   <= mul_q;
				default: ;
			endcase
		end
		if (emit) begin
			out_kind_q <= word_kind;
			out_chan_q <= 3'(chan_q) + 3'd1;
			out_word_q <= word_data;
			out_addr_q <= word_addr;
			out_last_q <= 1'b0;
		end else if (state_q == ST_RESET && slot_free) begin
			out_kind_q <= KIND_ACC;
			out_chan_q <= 3'd0;
			out_word_q <= ACC_RESET;
			out_addr_q <= NO_ADDR;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_addr_q, out_word_q};
	assign m_tuser  = {out_chan_q, out_kind_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> design/ddsseq_store.sv
// ============================================================================
// ddsseq_store - per-channel settings store
// Clamps a set command and writes it to the selected channel; one read port
// indexed by the sequencer's channel counter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ddsseq_store
	import ddsseq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [7:0]          wr_sel,
	input  wire logic [31:0]         wr_freq,
	input  wire logic [15:0]         wr_phase,
	input  wire logic [15:0]         wr_amp,
	input  wire logic [CH_IDX_W-1:0] rd_idx,
	output logic      [FREQ_W-1:0]   rd_freq,
	output logic      [PH_W-1:0]     rd_phase,
	output logic      [AMP_W-1:0]    rd_amp
);

	logic [FREQ_W-1:0]   freq_q  [CHANNELS];
	logic [PH_W-1:0]     phase_q [CHANNELS];
	logic [AMP_W-1:0]    amp_q   [CHANNELS];
	logic                sel_ok;
	logic [CH_IDX_W-1:0] wr_idx;
	logic [7:0]          sel_m1;
	logic [FREQ_W-1:0]   freq_c;
	logic [PH_W-1:0]     phase_c;
	logic [AMP_W-1:0]    amp_c;

	assign sel_ok  = (wr_sel != 8'd0) && (wr_sel <= 8'(CHANNELS));
	assign sel_m1  = wr_sel - 8'd1;
	assign wr_idx  = sel_m1[CH_IDX_W-1:0];
	assign freq_c  = (wr_freq > FREQ_LIMIT) ? FREQ_MAX : FREQ_W'(wr_freq);
	assign phase_c = (wr_phase > PH_LIMIT) ? PH_MAX : PH_W'(wr_phase);
	assign amp_c   = (wr_amp > AMP_LIMIT) ? AMP_MAX : AMP_W'(wr_amp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				freq_q[i]  <= '0;
				phase_q[i] <= '0;
				amp_q[i]   <= '0;
			end
		end else if (wr_en && sel_ok) begin
			freq_q[wr_idx]  <= freq_c;
			phase_q[wr_idx] <= phase_c;
			amp_q[wr_idx]   <= amp_c;
		end
	end

	assign rd_freq  = freq_q[rd_idx];
	assign rd_phase = phase_q[rd_idx];
	assign rd_amp   = amp_q[rd_idx];

endmodule

`default_nettype wire

>>> design/ddsseq_mul.sv
// ============================================================================
// ddsseq_mul - shared constant-divide unit
// Registered multiply by a reciprocal constant, then a shift chosen by the
// operation; gives the truncated quotient in the cycle after issue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ddsseq_mul
	import ddsseq_pkg::*;
(
	input  wire logic             clk,
	input  wire mul_op_t          op,
	input  wire logic [MX_W-1:0]  x,
	output logic      [QUO_W-1:0] q
);

	logic [PROD_W-1:0] prod_s1;
	mul_op_t           op_s1;
	logic [PROD_W-1:0] shifted;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(x) * PROD_W'(mul_const(op));
		op_s1   <= op;
	end

	always_comb begin
		unique case (op_s1)
			OP_DIV7:    shifted = prod_s1 >> DIV7_S;
			OP_DIV360:  shifted = prod_s1 >> DIV360_S;
			OP_DIV_SPI: shifted = prod_s1 >> DIVSPI_S;
			OP_DIV_I2C: shifted = prod_s1 >> DIVI2C_S;
			default:    shifted = '0;
		endcase
	end

	assign q = shifted[QUO_W-1:0];

endmodule

`default_nettype wire

>>> verif/tb_four_channel_dds_command_sequencer.sv
// ============================================================================
// tb_four_channel_dds_command_sequencer - self-checking bench for the sequencer
// Sends set commands on the input stream and predicts the full serial word
// run of every command from a local copy of the channel settings. Each output
// transfer is checked against the oldest predicted word. A directed set
// covers the clamp boundaries and the out-of-range channels. Random commands
// then run under phases of sender idling and receiver stalling.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb_four_channel_dds_command_sequencer;
	import ddsseq_pkg::*;

	localparam logic [31:0] FREQ_MASK   = 32'h3FFF;
	localparam logic [31:0] PHASE_SCALE = 32'd4096;
	localparam logic [31:0] PHASE_DIV   = 32'd360;
	localparam logic [31:0] AMP_DIV     = 32'd7;
	localparam logic [31:0] DAC_SCALE   = 32'd4096;
	localparam logic [31:0] SPI_FS      = 32'd2500;
	localparam logic [31:0] I2C_FS      = 32'd3300;
	localparam int RANDOM_PER_PHASE     = 36;
	localparam int TAIL_CYCLES          = 6 * CHANNELS + 8;
	localparam int WATCHDOG_LIMIT       = 5000;
	localparam int MAX_REPORTS          = 10;

	typedef struct packed {
		logic [7:0]  sel;
		logic [31:0] freq;
		logic [15:0] phase;
		logic [15:0] ampl;
	} dds_cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  chan;
		logic [15:0] word;
		logic [7:0]  addr;
		logic        last;
	} serial_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // frequency_hz, phase_deg, amplitude_mv
	logic [7:0]  s_tuser = '0;   // channel_sel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // data_word, bus_address
	logic [4:0]  m_tuser;        // target_kind, target_channel
	logic        m_tlast;

	dds_cmd_t     pending_cmds[$];
	serial_word_t expected_words[$];
	dds_cmd_t     next_cmd;
	serial_word_t got_word;
	serial_word_t want_word;

	// local copy of the channel settings
	logic [FREQ_W-1:0] freq_store[CHANNELS];
	logic [PH_W-1:0]   phase_store[CHANNELS];
	logic [AMP_W-1:0]  ampl_store[CHANNELS];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int idle_cycles = 0;

	four_channel_dds_command_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic serial_word_t make_word(logic [1:0] kind, logic [2:0] chan,
		logic [31:0] word, logic [7:0] addr, logic last);
		serial_word_t w;
		w.kind = kind;
		w.chan = chan;
		w.word = word[15:0];
		w.addr = addr;
		w.last = last;
		return w;
	endfunction

	// update the selected channel, then queue the words of the whole run
	task automatic predict_run(input logic [7:0] sel, input logic [63:0] data);
		logic [31:0] freq;
		logic [15:0] phase;
		logic [15:0] ampl;
		logic [31:0] fw;
		logic [31:0] base;
		logic [2:0]  chan;
		int          idx;
		freq  = data[31:0];
		phase = data[47:32];
		ampl  = data[63:48];
		if (sel >= 8'd1 && sel <= 8'(CHANNELS)) begin
			idx = int'(sel) - 1;
			freq_store[idx]  = (freq > FREQ_LIMIT) ? FREQ_MAX : freq[FREQ_W-1:0];
			phase_store[idx] = (phase > PH_LIMIT) ? PH_MAX : phase[PH_W-1:0];
			ampl_store[idx]  = (ampl > AMP_LIMIT) ? AMP_MAX : ampl[AMP_W-1:0];
		end
		for (int k = 0; k < CHANNELS; k++) begin
			chan = 3'(k + 1);
			fw   = 32'(freq_store[k]) * 32'd4;
			base = 32'(DAC_MID) - (32'(ampl_store[k]) * 32'd4) / AMP_DIV;
			expected_words.push_back(make_word(KIND_DDS, chan, 32'(DDS_CTRL), NO_ADDR, 1'b0));
			expected_words.push_back(make_word(KIND_DDS, chan,
				(fw & FREQ_MASK) + 32'(FREQ_TAG), NO_ADDR, 1'b0));
			expected_words.push_back(make_word(KIND_DDS, chan,
				(fw >> 14) + 32'(FREQ_TAG), NO_ADDR, 1'b0));
			expected_words.push_back(make_word(KIND_DDS, chan,
				(PHASE_SCALE * 32'(phase_store[k])) / PHASE_DIV + 32'(PHASE_TAG),
				NO_ADDR, 1'b0));
			expected_words.push_back(make_word(KIND_SPI, chan,
				((base * DAC_SCALE) / SPI_FS) << 2, NO_ADDR, 1'b0));
			expected_words.push_back(make_word(KIND_I2C, chan,
				(base * DAC_SCALE) / I2C_FS, (k == 0) ? DAC_ADDR0 : DAC_ADDR1, 1'b0));
		end
		expected_words.push_back(make_word(KIND_ACC, 3'd0, 32'(ACC_RESET), NO_ADDR, 1'b1));
	endtask

	task automatic add_cmd(input logic [7:0] sel, input logic [31:0] freq,
		input logic [15:0] phase, input logic [15:0] ampl);
		dds_cmd_t c;
		c.sel   = sel;
		c.freq  = freq;
		c.phase = phase;
		c.ampl  = ampl;
		pending_cmds.push_back(c);
	endtask

	// mostly in range, some at the clamp boundary, some over the full width
	function automatic logic [31:0] pick_field(logic [31:0] limit, int width);
		logic [31:0] mask;
		logic [31:0] v;
		mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
		case ($urandom_range(3))
			0, 1: v = $urandom_range(limit);
			2:    v = limit - 32'd1 + $urandom_range(2);
			default: v = $urandom() & mask;
		endcase
		return v & mask;
	endfunction

	function automatic logic [7:0] pick_channel();
		logic [7:0] s;
		case ($urandom_range(9))
			8:       s = ($urandom_range(1) == 0) ? 8'd0 : 8'(CHANNELS + 1);
			9:       s = 8'($urandom());
			default: s = 8'($urandom_range(CHANNELS, 1));
		endcase
		return s;
	endfunction

	task automatic add_random(input int count);
		for (int n = 0; n < count; n++)
			add_cmd(pick_channel(), pick_field(FREQ_LIMIT, 32),
				16'(pick_field(32'(PH_LIMIT), 16)), 16'(pick_field(32'(AMP_LIMIT), 16)));
	endtask

	task automatic drain_commands();
		while (pending_cmds.size() != 0 || s_tvalid)
			@(negedge clk);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			for (int k = 0; k < CHANNELS; k++) begin
				freq_store[k]  = '0;
				phase_store[k] = '0;
				ampl_store[k]  = '0;
			end
		end else begin
			if (s_tvalid && s_tready)
				predict_run(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {next_cmd.ampl, next_cmd.phase, next_cmd.freq};
					s_tuser  <= next_cmd.sel;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// word monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_word.word = m_tdata[15:0];
				got_word.addr = m_tdata[23:16];
				got_word.kind = m_tuser[1:0];
				got_word.chan = m_tuser[4:2];
				got_word.last = m_tlast;
				if (expected_words.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("unexpected word: kind %0d ch %0d word %h addr %h last %b",
							got_word.kind, got_word.chan, got_word.word, got_word.addr,
							got_word.last);
					error_count = error_count + 1;
				end else begin
					want_word = expected_words.pop_front();
					if (got_word.kind !== want_word.kind || got_word.chan !== want_word.chan ||
						got_word.word !== want_word.word || got_word.addr !== want_word.addr ||
						got_word.last !== want_word.last) begin
						if (error_count < MAX_REPORTS) begin
							$display("mismatch: expected kind %0d ch %0d word %h addr %h last %b",
								want_word.kind, want_word.chan, want_word.word,
								want_word.addr, want_word.last);
							$display("          got kind %0d ch %0d word %h addr %h last %b",
								got_word.kind, got_word.chan, got_word.word,
								got_word.addr, got_word.last);
						end
						error_count = error_count + 1;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_four_channel_dds_command_sequencer failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// settings still at reset, then extremes and clamp boundaries
		add_cmd(8'd0, 32'd0, 16'd0, 16'd0);
		add_cmd(8'd1, 32'd0, 16'd0, 16'd0);
		add_cmd(8'd1, 32'd30000000, 16'd360, 16'd2100);
		add_cmd(8'd2, 32'd30000001, 16'd361, 16'd2101);
		add_cmd(8'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		add_cmd(8'd4, 32'd29999999, 16'd359, 16'd2099);
		add_cmd(8'd4, 32'd1, 16'd1, 16'd1);
		// channels outside the range leave every setting alone
		add_cmd(8'd5, 32'd12345, 16'd90, 16'd700);
		add_cmd(8'd255, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		add_cmd(8'd0, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
		add_cmd(8'd128, 32'h5555_5555, 16'hAAAA, 16'h5555);
		add_cmd(8'd2, 32'd4096, 16'd180, 16'd7);
		add_cmd(8'd3, 32'd16384, 16'd45, 16'd1050);
		add_cmd(8'd1, 32'd1000000, 16'd270, 16'd6);
		add_cmd(8'd2, 32'h8000_0000, 16'h8000, 16'h8000);
		add_cmd(8'd3, 32'd0, 16'd360, 16'd0);
		add_cmd(8'd4, 32'd30000000, 16'd0, 16'd2100);
		add_cmd(8'd1, 32'd4095, 16'd359, 16'd2101);
		add_random(RANDOM_PER_PHASE);
		drain_commands();

		send_idle_pct  = 51;
		recv_stall_pct = 0;
		add_random(RANDOM_PER_PHASE);
		drain_commands();

		send_idle_pct  = 0;
		recv_stall_pct = 51;
		add_random(RANDOM_PER_PHASE);
		drain_commands();

		send_idle_pct  = 18;
		recv_stall_pct = 18;
		add_random(RANDOM_PER_PHASE);
		drain_commands();

		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("tb_four_channel_dds_command_sequencer passed");
		end else begin
			$display("tb_four_channel_dds_command_sequencer failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
